// ===== design/bmre_pkg.sv =====
// ----------------------------------------------------------------------------
// bmre_pkg
// Shared types and constants for the bit matrix row engine: command kinds,
// field layout of the request word and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bmre_pkg;

    localparam int DEF_MAX_ROWS      = 256;
    localparam int DEF_MAX_ROW_WORDS = 8;

    localparam int WORD_W = 32;
    localparam int KIND_W = 4;
    localparam int ROW_W  = 8;
    localparam int WIDX_W = 3;
    localparam int CFG_W  = 4;

    localparam logic [CFG_W-1:0]  ROW_WORDS_RESET = 4'd8;
    localparam logic [WORD_W-1:0] ALL_ONES        = 32'hFFFF_FFFF;

    // request word layout
    localparam int KIND_LSB  = 0;
    localparam int ROW_A_LSB = KIND_LSB + KIND_W;
    localparam int ROW_B_LSB = ROW_A_LSB + ROW_W;
    localparam int DST_LSB   = ROW_B_LSB + ROW_W;
    localparam int WIDX_LSB  = DST_LSB + ROW_W;
    localparam int EXT_LSB   = WIDX_LSB + WIDX_W;
    localparam int S_TDATA_W = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_AND    = 4'd0,
        KIND_OR     = 4'd1,
        KIND_CMP    = 4'd2,
        KIND_COPY   = 4'd3,
        KIND_CLEAR  = 4'd4,
        KIND_SET    = 4'd5,
        KIND_W_AND  = 4'd6,
        KIND_W_OR   = 4'd7,
        KIND_W_WR   = 4'd8,
        KIND_READ   = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_RD_A,
        MEM_RD_B,
        MEM_WR
    } mem_op_t;

    typedef struct packed {
        logic    load;
        mem_op_t mem_op;
        logic    cap_a;
        logic    next_word;
        logic    upd_eq;
        logic    out_word;
        logic    out_eq;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  word_ok;
        logic  last_word;
        logic  out_free;
    } ctrl_stat_t;

endpackage

// ===== design/bmre_store.sv =====
// ----------------------------------------------------------------------------
// bmre_store
// Single-port word store with registered read data.
// ----------------------------------------------------------------------------
module bmre_store #(
    parameter int DEPTH  = bmre_pkg::DEF_MAX_ROWS * bmre_pkg::DEF_MAX_ROW_WORDS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           addr,
    input  logic [bmre_pkg::WORD_W-1:0] wdata,
    output logic [bmre_pkg::WORD_W-1:0] rdata
);

    logic [bmre_pkg::WORD_W-1:0] mem [DEPTH];
    logic [bmre_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bmre_datapath.sv =====
// ----------------------------------------------------------------------------
// bmre_datapath
// Request capture, row addressing, word operations, compare flag, the
// row-words register and the result register.
// ----------------------------------------------------------------------------
module bmre_datapath #(
    parameter int MAX_ROWS      = bmre_pkg::DEF_MAX_ROWS,
    parameter int MAX_ROW_WORDS = bmre_pkg::DEF_MAX_ROW_WORDS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bmre_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic [bmre_pkg::S_TDATA_W-1:0] s_tdata,
    input  bmre_pkg::ctrl_cmd_t            cmd,
    output bmre_pkg::ctrl_stat_t           stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bmre_pkg::WORD_W-1:0]    m_tdata,
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast
);

    localparam int DEPTH  = MAX_ROWS * MAX_ROW_WORDS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int OFF_W  = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROW_WORDS + 1);
    localparam int MOD_SH = bmre_pkg::ROW_W + $clog2(MAX_ROWS);
    localparam int MOD_M  = ((1 << MOD_SH) + MAX_ROWS - 1) / MAX_ROWS;

    logic [bmre_pkg::CFG_W-1:0]  row_words_reg;
    logic [CNT_W-1:0]            n_words;
    bmre_pkg::kind_t             kind_reg;
    logic                        is_word_reg;
    logic                        word_ok_reg;
    logic [ADDR_W-1:0]           a_base_reg;
    logic [ADDR_W-1:0]           b_base_reg;
    logic [ADDR_W-1:0]           d_base_reg;
    logic [OFF_W-1:0]            off_reg;
    logic [bmre_pkg::WORD_W-1:0] ext_reg;
    logic [bmre_pkg::WORD_W-1:0] a_reg;
    logic                        eq_reg;
    logic                        out_valid_reg;
    logic [bmre_pkg::WORD_W-1:0] out_data_reg;
    logic                        out_eq_reg;
    logic                        out_last_reg;

    logic [bmre_pkg::KIND_W-1:0] in_kind;
    logic [bmre_pkg::WIDX_W-1:0] in_widx;
    logic                        in_is_word;
    logic                        last_word;
    logic                        mem_en;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_addr;
    logic [bmre_pkg::WORD_W-1:0] mem_wdata;
    logic [bmre_pkg::WORD_W-1:0] mem_rdata;

    // row index modulo MAX_ROWS by reciprocal multiplication
    function automatic logic [ROW_AW-1:0] row_mod(input logic [bmre_pkg::ROW_W-1:0] r);
        logic [31:0] quo;
        logic [31:0] rem;
        quo = (32'(r) * 32'(MOD_M)) >> MOD_SH;
        rem = 32'(r) - quo * 32'(MAX_ROWS);
        return ROW_AW'(rem);
    endfunction

    function automatic logic [ADDR_W-1:0] row_base(input logic [bmre_pkg::ROW_W-1:0] r);
        return ADDR_W'(32'(row_mod(r)) * 32'(MAX_ROW_WORDS));
    endfunction

    assign in_kind    = s_tdata[bmre_pkg::KIND_LSB +: bmre_pkg::KIND_W];
    assign in_widx    = s_tdata[bmre_pkg::WIDX_LSB +: bmre_pkg::WIDX_W];
    assign in_is_word = (in_kind == bmre_pkg::KIND_W_AND) || (in_kind == bmre_pkg::KIND_W_OR)
                     || (in_kind == bmre_pkg::KIND_W_WR);

    always_comb begin
        if (row_words_reg == '0) begin
            n_words = CNT_W'(1);
        end else if (32'(row_words_reg) > 32'(MAX_ROW_WORDS)) begin
            n_words = CNT_W'(MAX_ROW_WORDS);
        end else begin
            n_words = CNT_W'(row_words_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_words_reg <= bmre_pkg::ROW_WORDS_RESET;
        end else if (cfg_wr_en) begin
            row_words_reg <= cfg_wr_data;
        end
    end

    // request capture and word walk
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= bmre_pkg::kind_t'(in_kind);
            is_word_reg <= in_is_word;
            word_ok_reg <= 32'(in_widx) < 32'(n_words);
            a_base_reg  <= row_base(s_tdata[bmre_pkg::ROW_A_LSB +: bmre_pkg::ROW_W]);
            b_base_reg  <= row_base(s_tdata[bmre_pkg::ROW_B_LSB +: bmre_pkg::ROW_W]);
            d_base_reg  <= row_base(s_tdata[bmre_pkg::DST_LSB +: bmre_pkg::ROW_W]);
            off_reg     <= in_is_word ? OFF_W'(in_widx) : '0;
            ext_reg     <= s_tdata[bmre_pkg::EXT_LSB +: bmre_pkg::WORD_W];
        end else if (cmd.next_word) begin
            off_reg <= off_reg + OFF_W'(1);
        end
        if (cmd.cap_a) begin
            a_reg <= mem_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            eq_reg <= 1'b1;
        end else if (cmd.upd_eq) begin
            eq_reg <= eq_reg & (a_reg == mem_rdata);
        end
    end

    assign last_word = is_word_reg
                    || ((CNT_W'(off_reg) + CNT_W'(1)) == n_words);

    // store port
    always_comb begin
        mem_en = (cmd.mem_op != bmre_pkg::MEM_NONE);
        mem_we = (cmd.mem_op == bmre_pkg::MEM_WR);
        unique case (cmd.mem_op)
            bmre_pkg::MEM_RD_A: mem_addr = a_base_reg + ADDR_W'(off_reg);
            bmre_pkg::MEM_RD_B: mem_addr = b_base_reg + ADDR_W'(off_reg);
            default:            mem_addr = d_base_reg + ADDR_W'(off_reg);
        endcase
    end

    always_comb begin
        unique case (kind_reg)
            bmre_pkg::KIND_AND:   mem_wdata = a_reg & mem_rdata;
            bmre_pkg::KIND_OR:    mem_wdata = a_reg | mem_rdata;
            bmre_pkg::KIND_COPY:  mem_wdata = a_reg;
            bmre_pkg::KIND_SET:   mem_wdata = bmre_pkg::ALL_ONES;
            bmre_pkg::KIND_W_AND: mem_wdata = a_reg & ext_reg;
            bmre_pkg::KIND_W_OR:  mem_wdata = a_reg | ext_reg;
            bmre_pkg::KIND_W_WR:  mem_wdata = ext_reg;
            default:              mem_wdata = '0;
        endcase
    end

    bmre_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_word || cmd.out_eq) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_word) begin
            out_data_reg <= mem_rdata;
            out_eq_reg   <= 1'b0;
            out_last_reg <= last_word;
        end else if (cmd.out_eq) begin
            out_data_reg <= '0;
            out_eq_reg   <= eq_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_eq_reg;
    assign m_tlast    = out_last_reg;

    assign stat.kind      = kind_reg;
    assign stat.word_ok   = word_ok_reg;
    assign stat.last_word = last_word;
    assign stat.out_free  = !out_valid_reg || m_tready;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !(cmd.out_word || cmd.out_eq))
        else $error("result register overwritten while held");

    a_off_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mem_op != bmre_pkg::MEM_NONE) |-> (32'(off_reg) < 32'(n_words)))
        else $error("store access past used words of row");

    a_eq_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_eq |=> (out_valid_reg && out_last_reg && (out_data_reg == '0)))
        else $error("compare result not presented as single last item");

endmodule

// ===== design/bmre_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmre_ctrl
// Command sequencer: walks a row's used words or one indexed word, with up to
// two reads, one write per word on the single store port, and issues results.
// ----------------------------------------------------------------------------
module bmre_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  bmre_pkg::ctrl_stat_t  stat,
    output bmre_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISP,
        ST_RA,
        ST_RB,
        ST_OP,
        ST_RW,
        ST_EQ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fill_only;

    assign fill_only = (stat.kind == bmre_pkg::KIND_CLEAR) || (stat.kind == bmre_pkg::KIND_SET)
                    || (stat.kind == bmre_pkg::KIND_W_WR);

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mem_op    = bmre_pkg::MEM_NONE;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (stat.kind)
                    bmre_pkg::KIND_AND, bmre_pkg::KIND_OR, bmre_pkg::KIND_CMP,
                    bmre_pkg::KIND_COPY, bmre_pkg::KIND_READ: begin
                        state_next = ST_RA;
                    end
                    bmre_pkg::KIND_CLEAR, bmre_pkg::KIND_SET: begin
                        state_next = ST_OP;
                    end
                    bmre_pkg::KIND_W_AND, bmre_pkg::KIND_W_OR: begin
                        state_next = stat.word_ok ? ST_RA : ST_IDLE;
                    end
                    bmre_pkg::KIND_W_WR: begin
                        state_next = stat.word_ok ? ST_OP : ST_IDLE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RA: begin
                cmd.mem_op = bmre_pkg::MEM_RD_A;
                state_next = (stat.kind == bmre_pkg::KIND_READ) ? ST_RW : ST_RB;
            end
            ST_RB: begin
                cmd.mem_op = bmre_pkg::MEM_RD_B;
                cmd.cap_a  = 1'b1;
                state_next = ST_OP;
            end
            ST_OP: begin
                if (stat.kind == bmre_pkg::KIND_CMP) begin
                    cmd.upd_eq = 1'b1;
                end else begin
                    cmd.mem_op = bmre_pkg::MEM_WR;
                end
                if (stat.last_word) begin
                    state_next = (stat.kind == bmre_pkg::KIND_CMP) ? ST_EQ : ST_IDLE;
                end else begin
                    cmd.next_word = 1'b1;
                    state_next    = fill_only ? ST_OP : ST_RA;
                end
            end
            ST_RW: begin
                if (stat.out_free) begin
                    cmd.out_word = 1'b1;
                    if (stat.last_word) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_word = 1'b1;
                        state_next    = ST_RA;
                    end
                end
            end
            ST_EQ: begin
                if (stat.out_free) begin
                    cmd.out_eq = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/bit_matrix_row_engine.sv =====
// ----------------------------------------------------------------------------
// bit_matrix_row_engine
// Bit matrix held as rows of 32-bit words, with row and word commands.
// ----------------------------------------------------------------------------
// One request is taken at a time; s_tready is high only between requests.
// All work goes through one single-port store. With n used words per row,
// AND, OR, copy and compare read each word of rows a and b, then write or
// compare it; compare then presents its result. Clear and set only write
// each word, and a read presents each word of row a. A word command whose
// word index is not below n, or an unknown kind, changes nothing. A result
// waiting in the output register does not block a new request. The
// row-words register must be written only while the engine is idle; the
// engine does not enforce it. Store contents are undefined after reset
// until written; there is no clearing pass.
module bit_matrix_row_engine #(
    parameter int MAX_ROWS      = bmre_pkg::DEF_MAX_ROWS,
    parameter int MAX_ROW_WORDS = bmre_pkg::DEF_MAX_ROW_WORDS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bmre_pkg::CFG_W-1:0]     cfg_wr_data,   // row_words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // kind, row_a, row_b, dst_row, word_index, ext_word, zero pad
    input  logic [bmre_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bmre_pkg::WORD_W-1:0]    m_tdata,       // read_word
    output logic [0:0]                     m_tuser,       // equal
    output logic                           m_tlast
);

    bmre_pkg::ctrl_cmd_t  cmd;
    bmre_pkg::ctrl_stat_t stat;

    bmre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bmre_datapath #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_ROW_WORDS (MAX_ROW_WORDS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== verif/tb_bit_matrix_row_engine.sv =====
// ----------------------------------------------------------------------------
// tb_bit_matrix_row_engine
// Self-checking bench for the bit matrix row engine. A short list of directed
// requests walks the command kinds, the row and word extremes and the unused
// kind codes. Random requests then run under several row-words settings,
// written while the engine is idle. Requests that would read undefined store
// words are turned into clears or sets of those rows. A behavioral image of
// the matrix predicts results not fixed by the directed list; each returned
// word is checked in order. Both stream sides pause at random, and the
// result side now and then holds off long enough to stall the request side.
// ----------------------------------------------------------------------------
module tb_bit_matrix_row_engine;

    import bmre_pkg::*;

    localparam int ROW_COUNT       = DEF_MAX_ROWS;
    localparam int ROW_STRIDE      = DEF_MAX_ROW_WORDS;
    localparam int IMAGE_DEPTH     = ROW_COUNT * ROW_STRIDE;
    localparam int ITEMS_PER_PHASE = 51;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_SPACING    = 5000;
    localparam int CYCLE_LIMIT     = 1_000_000;

    localparam logic [KIND_W-1:0] KIND_RSVD_LO = 4'd10;
    localparam logic [KIND_W-1:0] KIND_RSVD_HI = 4'd15;

    typedef struct packed {
        logic [WORD_W-1:0] ext_word;
        logic [WIDX_W-1:0] word_index;
        logic [ROW_W-1:0]  dst_row;
        logic [ROW_W-1:0]  row_b;
        logic [ROW_W-1:0]  row_a;
        logic [KIND_W-1:0] kind;
    } row_request_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              equal;
        logic              last;
    } row_result_t;

    typedef struct {
        row_request_t      req;
        bit                typed;
        logic [WORD_W-1:0] word;
        logic              equal;
    } directed_row_t;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [WORD_W-1:0]    m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    logic [WORD_W-1:0] matrix_image [IMAGE_DEPTH];
    bit                word_defined [IMAGE_DEPTH];
    logic [CFG_W-1:0]  row_words_cfg = ROW_WORDS_RESET;
    row_result_t       awaited_results [$];
    directed_row_t     directed_rows [$];
    logic [ROW_W-1:0]  hot_rows [16];
    int                error_count = 0;
    int                cycle_count = 0;

    bit_matrix_row_engine dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int used_words_now();
        if (row_words_cfg == 0) return 1;
        if (row_words_cfg > ROW_STRIDE) return ROW_STRIDE;
        return int'(row_words_cfg);
    endfunction

    function automatic int row_base(input logic [ROW_W-1:0] row);
        return (int'(row) % ROW_COUNT) * ROW_STRIDE;
    endfunction

    function automatic bit row_defined(input logic [ROW_W-1:0] row, input int first,
                                       input int count);
        for (int i = first; i < first + count; i++)
            if (!word_defined[row_base(row) + i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    task automatic store_word(input int idx, input logic [WORD_W-1:0] value);
        matrix_image[idx] = value;
        word_defined[idx] = 1'b1;
    endtask

    // updates the matrix image for one accepted request; if record, queues results
    task automatic run_row_command(input row_request_t r, input bit record);
        int n, a, b, d, w;
        bit same;
        n = used_words_now();
        a = row_base(r.row_a);
        b = row_base(r.row_b);
        d = row_base(r.dst_row);
        w = int'(r.word_index);
        case (r.kind)
            KIND_AND:
                for (int i = 0; i < n; i++)
                    store_word(d + i, matrix_image[a + i] & matrix_image[b + i]);
            KIND_OR:
                for (int i = 0; i < n; i++)
                    store_word(d + i, matrix_image[a + i] | matrix_image[b + i]);
            KIND_CMP: begin
                same = 1'b1;
                for (int i = 0; i < n; i++)
                    if (matrix_image[a + i] != matrix_image[b + i]) same = 1'b0;
                if (record) awaited_results.push_back('{'0, same, 1'b1});
            end
            KIND_COPY:
                for (int i = 0; i < n; i++) store_word(d + i, matrix_image[a + i]);
            KIND_CLEAR:
                for (int i = 0; i < n; i++) store_word(d + i, '0);
            KIND_SET:
                for (int i = 0; i < n; i++) store_word(d + i, ALL_ONES);
            KIND_W_AND:
                if (w < n) store_word(d + w, matrix_image[a + w] & r.ext_word);
            KIND_W_OR:
                if (w < n) store_word(d + w, matrix_image[a + w] | r.ext_word);
            KIND_W_WR:
                if (w < n) store_word(d + w, r.ext_word);
            KIND_READ:
                if (record)
                    for (int i = 0; i < n; i++)
                        awaited_results.push_back('{matrix_image[a + i], 1'b0, i == n - 1});
            default: ;
        endcase
    endtask

    task automatic add_directed(input logic [KIND_W-1:0] kind, input logic [ROW_W-1:0] a,
                                input logic [ROW_W-1:0] b, input logic [ROW_W-1:0] d,
                                input logic [WIDX_W-1:0] w, input logic [WORD_W-1:0] ext,
                                input bit typed, input logic [WORD_W-1:0] word,
                                input logic equal);
        directed_rows.push_back('{'{ext, w, d, b, a, kind}, typed, word, equal});
    endtask

    function automatic logic [ROW_W-1:0] pick_row();
        if ($urandom_range(0, 3) == 0) return ROW_W'($urandom_range(0, 255));
        return hot_rows[$urandom_range(0, 15)];
    endfunction

    // random request; one that would read undefined words sets up its row instead
    function automatic row_request_t random_request();
        row_request_t r;
        int pick, n;
        bit ready;
        n = used_words_now();
        pick = $urandom_range(0, 99);
        if (pick < 12)      r.kind = KIND_AND;
        else if (pick < 24) r.kind = KIND_OR;
        else if (pick < 36) r.kind = KIND_CMP;
        else if (pick < 46) r.kind = KIND_COPY;
        else if (pick < 51) r.kind = KIND_CLEAR;
        else if (pick < 56) r.kind = KIND_SET;
        else if (pick < 66) r.kind = KIND_W_AND;
        else if (pick < 76) r.kind = KIND_W_OR;
        else if (pick < 84) r.kind = KIND_W_WR;
        else if (pick < 96) r.kind = KIND_READ;
        else                r.kind = KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
        r.row_a      = pick_row();
        r.row_b      = pick_row();
        r.dst_row    = pick_row();
        r.word_index = WIDX_W'($urandom_range(0, 7));
        pick = $urandom_range(0, 9);
        if (pick == 0)      r.ext_word = '0;
        else if (pick == 1) r.ext_word = ALL_ONES;
        else                r.ext_word = $urandom;
        case (r.kind)
            KIND_AND, KIND_OR, KIND_CMP:
                ready = row_defined(r.row_a, 0, n) && row_defined(r.row_b, 0, n);
            KIND_COPY, KIND_READ:
                ready = row_defined(r.row_a, 0, n);
            KIND_W_AND, KIND_W_OR:
                ready = (r.word_index >= n) || row_defined(r.row_a, r.word_index, 1);
            default:
                ready = 1'b1;
        endcase
        if (!ready) begin
            r.dst_row = row_defined(r.row_a, 0, n) ? r.row_b : r.row_a;
            r.kind    = $urandom_range(0, 1) ? KIND_SET : KIND_CLEAR;
        end
        return r;
    endfunction

    task automatic offer_request(input row_request_t r);
        s_tdata  <= S_TDATA_W'(r);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pause_sender();
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic settle_engine();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_row_words(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        row_words_cfg = value;
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] phase_cfg [8];
        int n;
        phase_cfg = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd8, 4'd5, 4'd2};
        hot_rows[0] = 8'd0;
        hot_rows[1] = 8'd255;
        for (int i = 2; i < 16; i++) hot_rows[i] = ROW_W'($urandom_range(0, 255));

        add_directed(KIND_CLEAR, 8'd0, 8'd0, 8'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        add_directed(KIND_SET, 8'd0, 8'd0, 8'd255, 3'd0, '0, 1'b0, '0, 1'b0);
        add_directed(KIND_CMP, 8'd0, 8'd255, 8'd0, 3'd0, '0, 1'b1, '0, 1'b0);
        add_directed(KIND_CMP, 8'd255, 8'd255, 8'd0, 3'd0, '0, 1'b1, '0, 1'b1);
        add_directed(KIND_READ, 8'd255, 8'd0, 8'd0, 3'd0, '0, 1'b1, ALL_ONES, 1'b0);
        add_directed(KIND_READ, 8'd0, 8'd0, 8'd0, 3'd0, '0, 1'b1, '0, 1'b0);
        add_directed(KIND_W_WR, 8'd0, 8'd0, 8'd0, 3'd0, ALL_ONES, 1'b0, '0, 1'b0);
        add_directed(KIND_W_WR, 8'd0, 8'd0, 8'd0, 3'd7, 32'h8000_0001, 1'b0, '0, 1'b0);
        add_directed(KIND_COPY, 8'd255, 8'd0, 8'd170, 3'd0, '0, 1'b0, '0, 1'b0);
        add_directed(KIND_CLEAR, 8'd0, 8'd0, 8'd85, 3'd0, '0, 1'b0, '0, 1'b0);
        add_directed(KIND_W_OR, 8'd0, 8'd0, 8'd85, 3'd7, 32'h0000_FFFF, 1'b0, '0, 1'b0);
        add_directed(KIND_W_AND, 8'd170, 8'd0, 8'd85, 3'd3, 32'h5A5A_A5A5, 1'b0, '0, 1'b0);
        add_directed(KIND_AND, 8'd255, 8'd85, 8'd1, 3'd0, '0, 1'b0, '0, 1'b0);
        add_directed(KIND_OR, 8'd0, 8'd85, 8'd2, 3'd0, '0, 1'b0, '0, 1'b0);
        add_directed(KIND_READ, 8'd2, 8'd0, 8'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        add_directed(KIND_READ, 8'd1, 8'd0, 8'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        add_directed(KIND_RSVD_HI, 8'd255, 8'd255, 8'd0, 3'd7, ALL_ONES, 1'b0, '0, 1'b0);
        add_directed(KIND_RSVD_LO, 8'd0, 8'd0, 8'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        add_directed(KIND_CMP, 8'd1, 8'd2, 8'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        add_directed(KIND_OR, 8'd0, 8'd255, 8'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        add_directed(KIND_CMP, 8'd0, 8'd255, 8'd0, 3'd0, '0, 1'b1, '0, 1'b1);
        add_directed(KIND_READ, 8'd0, 8'd0, 8'd0, 3'd0, '0, 1'b1, ALL_ONES, 1'b0);
        add_directed(KIND_READ, 8'd85, 8'd0, 8'd0, 3'd0, '0, 1'b0, '0, 1'b0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].req);
            if (directed_rows[i].typed) begin
                run_row_command(directed_rows[i].req, 1'b0);
                n = used_words_now();
                if (directed_rows[i].req.kind == KIND_CMP)
                    awaited_results.push_back('{'0, directed_rows[i].equal, 1'b1});
                else
                    for (int k = 0; k < n; k++)
                        awaited_results.push_back('{directed_rows[i].word, 1'b0, k == n - 1});
            end else begin
                run_row_command(directed_rows[i].req, 1'b1);
            end
            pause_sender();
        end

        foreach (phase_cfg[p]) begin
            settle_engine();
            write_row_words(phase_cfg[p]);
            repeat (ITEMS_PER_PHASE) begin
                row_request_t r;
                r = random_request();
                offer_request(r);
                run_row_command(r, 1'b1);
                pause_sender();
            end
        end

        settle_engine();
        if (error_count == 0)
            $display("tb_bit_matrix_row_engine passed");
        else
            $display("tb_bit_matrix_row_engine failed");
        $finish;
    end

    // result side pacing, with a recurring long hold-off of m_tready
    initial begin : ready_pacing
        int spent, hold_at, burst, stall;
        spent   = 0;
        hold_at = 1500;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (spent >= hold_at) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                spent   += HOLD_CYCLES;
                hold_at = spent + HOLD_SPACING;
            end
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (burst) @(posedge aclk);
            stall = idle_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            spent += burst + stall;
        end
    end

    always @(posedge aclk) begin : result_check
        row_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("result with no request pending: read_word %h", m_tdata);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata !== want.word) begin
                    $error("read_word: expected %h, got %h", want.word, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== want.equal) begin
                    $error("equal: expected %b, got %b", want.equal, m_tuser[0]);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_bit_matrix_row_engine failed");
        $finish;
    end

endmodule
